/* rtl/core/morse_text_codec_top_defines.svh */
// assertion macros for the morse text codec top level
// expects clk and rst in the scope where the macros are used
`ifndef MORSE_TEXT_CODEC_TOP_DEFINES_SVH
`define MORSE_TEXT_CODEC_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define MTC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mtc same-cycle check failed");

// next-cycle implication, disabled during reset
`define MTC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mtc next-cycle check failed");

`endif

/* rtl/core/mtc_pkg.sv */
// shared types, character codes and symbol table for the morse text codec
// no dependencies; imported by every module of the block
package mtc_pkg;

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_Z = 8'h7A;
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  localparam logic [2:0] MAX_SYMBOLS = 3'd6;
  localparam logic [2:0] OVERLONG    = 3'd7;
  localparam logic [2:0] SPACE_TAIL  = 3'd2;
  localparam logic [1:0] RUN_WORD    = 2'd2;

  localparam int SYM_COUNT   = 40;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef struct packed {
    logic [2:0] len;
    logic [5:0] bits;   // first symbol highest, dash = 1
  } sym_code_t;

  // one queued job: a head character and an optional tail of spaces or symbols
  typedef struct packed {
    logic       tail_space;
    logic [5:0] tail_bits;  // left-aligned, next symbol in bit 5
    logic [2:0] tail_len;
    logic [7:0] head;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } q_wr_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  localparam logic [7:0] SYM_CHARS [SYM_COUNT] = '{
    8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46, 8'h47, 8'h48, 8'h49, 8'h4A,
    8'h4B, 8'h4C, 8'h4D, 8'h4E, 8'h4F, 8'h50, 8'h51, 8'h52, 8'h53, 8'h54,
    8'h55, 8'h56, 8'h57, 8'h58, 8'h59, 8'h5A, 8'h31, 8'h32, 8'h33, 8'h34,
    8'h35, 8'h36, 8'h37, 8'h38, 8'h39, 8'h30, 8'h2E, 8'h2C, 8'h3F, 8'h21
  };

  // character to pattern; unknown characters give length zero
  function automatic sym_code_t sym_encode(input logic [7:0] ch);
    sym_code_t code;
    case (ch)
      8'h41: code = {3'd2, 6'b01};
      8'h42: code = {3'd4, 6'b1000};
      8'h43: code = {3'd4, 6'b1010};
      8'h44: code = {3'd3, 6'b100};
      8'h45: code = {3'd1, 6'b0};
      8'h46: code = {3'd4, 6'b0010};
      8'h47: code = {3'd3, 6'b110};
      8'h48: code = {3'd4, 6'b0000};
      8'h49: code = {3'd2, 6'b00};
      8'h4A: code = {3'd4, 6'b0111};
      8'h4B: code = {3'd3, 6'b101};
      8'h4C: code = {3'd4, 6'b0100};
      8'h4D: code = {3'd2, 6'b11};
      8'h4E: code = {3'd2, 6'b10};
      8'h4F: code = {3'd3, 6'b111};
      8'h50: code = {3'd4, 6'b0110};
      8'h51: code = {3'd4, 6'b1101};
      8'h52: code = {3'd3, 6'b010};
      8'h53: code = {3'd3, 6'b000};
      8'h54: code = {3'd1, 6'b1};
      8'h55: code = {3'd3, 6'b001};
      8'h56: code = {3'd4, 6'b0001};
      8'h57: code = {3'd3, 6'b011};
      8'h58: code = {3'd4, 6'b1001};
      8'h59: code = {3'd4, 6'b1011};
      8'h5A: code = {3'd4, 6'b1100};
      8'h31: code = {3'd5, 6'b01111};
      8'h32: code = {3'd5, 6'b00111};
      8'h33: code = {3'd5, 6'b00011};
      8'h34: code = {3'd5, 6'b00001};
      8'h35: code = {3'd5, 6'b00000};
      8'h36: code = {3'd5, 6'b10000};
      8'h37: code = {3'd5, 6'b11000};
      8'h38: code = {3'd5, 6'b11100};
      8'h39: code = {3'd5, 6'b11110};
      8'h30: code = {3'd5, 6'b11111};
      8'h2E: code = {3'd6, 6'b010101};
      8'h2C: code = {3'd6, 6'b110011};
      8'h3F: code = {3'd6, 6'b001100};
      8'h21: code = {3'd6, 6'b101011};
      default: code = {3'd0, 6'b0};
    endcase
    return code;
  endfunction

  // pattern to character; no match (empty or overlong too) gives NUL
  function automatic logic [7:0] sym_decode(input sym_code_t code);
    logic [7:0] ch;
    ch = CH_NUL;
    for (int i = 0; i < SYM_COUNT; i++) begin
      if (code.len != 3'd0 && sym_encode(SYM_CHARS[6'(i)]) == code) begin
        ch = SYM_CHARS[6'(i)];
      end
    end
    return ch;
  endfunction

endpackage

/* rtl/core/mtc_front.sv */
// front end: accepts characters, holds the mode register and decode state,
// and turns each item into at most one queue entry; uses mtc_pkg
module mtc_front import mtc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,   // [7:0] char_in
  input  logic       s_tlast,   // end_of_text
  input  q_stat_t    q_stat,
  output q_wr_t      q_wr,
  output logic       mode
);

  logic       accept;
  logic [5:0] pat_bits;
  logic [2:0] pat_len;
  logic [1:0] space_run;
  logic [5:0] pat_bits_next;
  logic [2:0] pat_len_next;
  logic [1:0] space_run_next;
  logic [7:0] up_char;
  sym_code_t  enc_code;
  logic [7:0] gap_letter;
  logic [7:0] eot_letter;
  logic       dec_emit;
  logic [7:0] dec_char;
  entry_t     entry;

  assign s_tready = !q_stat.full;
  assign accept   = s_tvalid && s_tready;

  // encode side
  always_comb begin
    up_char = s_tdata;
    if (s_tdata inside {[CH_LOW_A:CH_LOW_Z]}) begin
      up_char = s_tdata - CASE_OFS;
    end
    enc_code = sym_encode(up_char);
  end

  // decode side: next pattern state and the one possible result
  always_comb begin
    pat_bits_next  = pat_bits;
    pat_len_next   = pat_len;
    space_run_next = space_run;
    dec_emit       = 1'b0;
    dec_char       = CH_NUL;
    gap_letter     = sym_decode({pat_len, pat_bits});
    if (s_tdata == CH_DOT || s_tdata == CH_DASH) begin
      space_run_next = 2'd0;
      if (pat_len < MAX_SYMBOLS) begin
        pat_bits_next = {pat_bits[4:0], s_tdata == CH_DASH};
        pat_len_next  = pat_len + 3'd1;
      end else begin
        pat_len_next = OVERLONG;
      end
    end else if (s_tdata == CH_SPACE) begin
      if (space_run == 2'd0 && gap_letter != CH_NUL) begin
        dec_emit = 1'b1;
        dec_char = gap_letter;
      end
      pat_bits_next = 6'd0;
      pat_len_next  = 3'd0;
      if (space_run == RUN_WORD) begin
        dec_emit       = 1'b1;
        dec_char       = CH_SPACE;
        space_run_next = 2'd0;
      end else begin
        space_run_next = space_run + 2'd1;
      end
    end
    // a space already cleared the pattern, so at most one letter comes out
    eot_letter = sym_decode({pat_len_next, pat_bits_next});
    if (s_tlast) begin
      if (eot_letter != CH_NUL) begin
        dec_emit = 1'b1;
        dec_char = eot_letter;
      end
      pat_bits_next  = 6'd0;
      pat_len_next   = 3'd0;
      space_run_next = 2'd0;
    end
  end

  always_comb begin
    entry = '0;
    if (mode == MODE_ENCODE) begin
      entry.head = CH_SPACE;
      if (s_tdata == CH_SPACE) begin
        entry.tail_space = 1'b1;
        entry.tail_len   = SPACE_TAIL;
      end else begin
        entry.tail_len  = enc_code.len;
        entry.tail_bits = 6'(enc_code.bits << (MAX_SYMBOLS - enc_code.len));
      end
    end else begin
      entry.head = dec_char;
    end
    q_wr.push  = accept && (mode == MODE_ENCODE || dec_emit);
    q_wr.entry = entry;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_ENCODE;
      pat_bits  <= 6'd0;
      pat_len   <= 3'd0;
      space_run <= 2'd0;
    end else begin
      if (cfg_we) begin
        mode <= cfg_wdata;
      end
      if (accept && mode == MODE_DECODE) begin
        pat_bits  <= pat_bits_next;
        pat_len   <= pat_len_next;
        space_run <= space_run_next;
      end
    end
  end

endmodule

/* rtl/core/mtc_queue.sv */
// two-entry job queue between front and back end
// uses mtc_pkg for the entry and handshake structs
module mtc_queue import mtc_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  q_wr_t   q_wr,
  input  logic    pop,
  output entry_t  rd_entry,
  output q_stat_t q_stat
);

  entry_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;

  assign rd_entry     = slots[rd_ptr];
  assign q_stat.full  = count == QCNT_W'(QUEUE_DEPTH);
  assign q_stat.empty = count == '0;

  always_ff @(posedge clk) begin
    if (q_wr.push) begin
      slots[wr_ptr] <= q_wr.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_wr.push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({q_wr.push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* rtl/core/mtc_back.sv */
// back end: pops queue entries and sends their characters one per cycle
// while m_tready allows, through a registered output stage; uses mtc_pkg
module mtc_back import mtc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  entry_t     rd_entry,
  input  q_stat_t    q_stat,
  output logic       pop,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,   // [7:0] char_out
  output logic       m_tlast    // last_of_run
);

  logic       advance;
  logic [2:0] remain;
  logic [5:0] sym_bits;
  logic       tail_space;

  assign advance = !m_tvalid || m_tready;
  assign pop     = advance && remain == 3'd0 && !q_stat.empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      remain   <= 3'd0;
    end else if (advance) begin
      if (remain != 3'd0) begin
        m_tvalid <= 1'b1;
        remain   <= remain - 3'd1;
      end else if (!q_stat.empty) begin
        m_tvalid <= 1'b1;
        remain   <= rd_entry.tail_len;
      end else begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (remain != 3'd0) begin
        m_tdata  <= tail_space ? CH_SPACE : (sym_bits[5] ? CH_DASH : CH_DOT);
        m_tlast  <= remain == 3'd1;
        sym_bits <= {sym_bits[4:0], 1'b0};
      end else if (!q_stat.empty) begin
        m_tdata    <= rd_entry.head;
        m_tlast    <= rd_entry.tail_len == 3'd0;
        sym_bits   <= rd_entry.tail_bits;
        tail_space <= rd_entry.tail_space;
      end
    end
  end

endmodule

/* rtl/core/morse_text_codec_top.sv */
// top level of the morse text codec: front end, job queue and back end
// depends on mtc_pkg, mtc_front, mtc_queue, mtc_back and the defines header
//
// usage:
//   s_* carries one ASCII character per item in s_tdata, s_tlast marks the
//   end of a text. m_* returns characters in m_tdata, m_tlast marking the
//   last character caused by one input item. cfg_we/cfg_wdata set the mode
//   (0 encode text to morse, 1 decode morse to text); write it only while
//   the block is idle.
// timing:
//   an encoded character gives 1 to 7 output characters: 3 for a space, 1
//   for an unknown byte, at most 7 for a six-symbol pattern; they go out one
//   per cycle while m_tready is high, and the queue keeps taking items.
//   decoding gives zero or one character per item and takes an item every
//   cycle unless the queue is full. output is registered in the back end.
// reset:
//   rst clears the mode to encode, the decode pattern, the queue and m_tvalid.
// stalls:
//   when m_tready is low the output holds; the two-entry queue keeps taking
//   items until it fills, then s_tready drops.
`include "morse_text_codec_top_defines.svh"

module morse_text_codec_top import mtc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,  // mode
  input  logic       s_tvalid,
  output logic       s_tready,
  input  logic [7:0] s_tdata,    // [7:0] char_in
  input  logic       s_tlast,    // end_of_text
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,    // [7:0] char_out
  output logic       m_tlast     // last_of_run
);

  q_wr_t   q_wr;
  q_stat_t q_stat;
  entry_t  rd_entry;
  logic    q_pop;
  logic    mode;

  mtc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .q_stat    (q_stat),
    .q_wr      (q_wr),
    .mode      (mode)
  );

  mtc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .q_wr     (q_wr),
    .pop      (q_pop),
    .rd_entry (rd_entry),
    .q_stat   (q_stat)
  );

  mtc_back u_back (
    .clk      (clk),
    .rst      (rst),
    .rd_entry (rd_entry),
    .q_stat   (q_stat),
    .pop      (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // every encoded character queues a job
  `MTC_ASSERT_IMP(a_enc_push, s_tvalid && s_tready && mode == MODE_ENCODE, q_wr.push)
  // back end never pops an empty queue
  `MTC_ASSERT_IMP(a_pop_nonempty, q_pop, !q_stat.empty)
  // a space job always carries exactly two trailing spaces
  `MTC_ASSERT_IMP(a_space_tail, q_wr.push && q_wr.entry.tail_space,
                  q_wr.entry.tail_len == SPACE_TAIL)

endmodule

/* bench/morse_text_codec_checker.sv */
// checker for the morse text codec: watches both streams and the mode port,
// predicts the characters each request causes and compares them in order
// depends on mtc_pkg for the character codes and limits
module morse_text_codec_checker import mtc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic       cfg_wdata,
  input  logic       s_tvalid,
  input  logic       s_tready,
  input  logic [7:0] s_tdata,
  input  logic       s_tlast,
  input  logic       m_tvalid,
  input  logic       m_tready,
  input  logic [7:0] m_tdata,
  input  logic       m_tlast,
  output int         fail_count,
  output int         pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } out_char_t;

  // symbol count and symbols, first symbol highest, dash = 1
  typedef struct packed {
    logic [2:0] n;
    logic [5:0] dashes;
  } morse_pat_t;

  out_char_t  expected_chars[$];
  logic       mode;
  logic [5:0] pat_dashes;
  logic [2:0] pat_len;
  logic [1:0] space_count;
  int         errors;

  function automatic morse_pat_t morse_of(input logic [7:0] ch);
    morse_pat_t p;
    case (ch)
      "A": p = {3'd2, 6'b01};     "B": p = {3'd4, 6'b1000};   "C": p = {3'd4, 6'b1010};
      "D": p = {3'd3, 6'b100};    "E": p = {3'd1, 6'b0};      "F": p = {3'd4, 6'b0010};
      "G": p = {3'd3, 6'b110};    "H": p = {3'd4, 6'b0000};   "I": p = {3'd2, 6'b00};
      "J": p = {3'd4, 6'b0111};   "K": p = {3'd3, 6'b101};    "L": p = {3'd4, 6'b0100};
      "M": p = {3'd2, 6'b11};     "N": p = {3'd2, 6'b10};     "O": p = {3'd3, 6'b111};
      "P": p = {3'd4, 6'b0110};   "Q": p = {3'd4, 6'b1101};   "R": p = {3'd3, 6'b010};
      "S": p = {3'd3, 6'b000};    "T": p = {3'd1, 6'b1};      "U": p = {3'd3, 6'b001};
      "V": p = {3'd4, 6'b0001};   "W": p = {3'd3, 6'b011};    "X": p = {3'd4, 6'b1001};
      "Y": p = {3'd4, 6'b1011};   "Z": p = {3'd4, 6'b1100};
      "1": p = {3'd5, 6'b01111};  "2": p = {3'd5, 6'b00111};  "3": p = {3'd5, 6'b00011};
      "4": p = {3'd5, 6'b00001};  "5": p = {3'd5, 6'b00000};  "6": p = {3'd5, 6'b10000};
      "7": p = {3'd5, 6'b11000};  "8": p = {3'd5, 6'b11100};  "9": p = {3'd5, 6'b11110};
      "0": p = {3'd5, 6'b11111};
      ".": p = {3'd6, 6'b010101}; ",": p = {3'd6, 6'b110011};
      "?": p = {3'd6, 6'b001100}; "!": p = {3'd6, 6'b101011};
      default: p = {3'd0, 6'b0};
    endcase
    return p;
  endfunction

  // reverse lookup over every byte; empty and overlong patterns never match
  function automatic logic [7:0] letter_of(input logic [2:0] n, input logic [5:0] d);
    logic [7:0] hit;
    morse_pat_t p;
    hit = CH_NUL;
    if (n != 3'd0 && n <= MAX_SYMBOLS) begin
      for (int c = 0; c < 256; c++) begin
        p = morse_of(c[7:0]);
        if (p.n == n && p.dashes == d) begin
          hit = c[7:0];
        end
      end
    end
    return hit;
  endfunction

  task automatic translate_item(input logic [7:0] c, input logic eot);
    logic [7:0] burst [7];
    int         n;
    logic [7:0] uc;
    logic [7:0] l;
    morse_pat_t p;
    n = 0;
    if (mode == MODE_ENCODE) begin
      burst[0] = CH_SPACE;
      n = 1;
      if (c == CH_SPACE) begin
        burst[1] = CH_SPACE;
        burst[2] = CH_SPACE;
        n = 3;
      end else begin
        uc = (c >= CH_LOW_A && c <= CH_LOW_Z) ? c - CASE_OFS : c;
        p = morse_of(uc);
        for (int k = 5; k >= 0; k--) begin
          if (k < p.n) begin
            burst[3'(n)] = p.dashes[3'(k)] ? CH_DASH : CH_DOT;
            n = n + 1;
          end
        end
      end
    end else begin
      if (c == CH_DOT || c == CH_DASH) begin
        space_count = 2'd0;
        if (pat_len < MAX_SYMBOLS) begin
          pat_dashes = {pat_dashes[4:0], c == CH_DASH};
          pat_len = pat_len + 3'd1;
        end else begin
          pat_len = OVERLONG;
        end
      end else if (c == CH_SPACE) begin
        // first space of a run ends the letter
        if (space_count == 2'd0) begin
          l = letter_of(pat_len, pat_dashes);
          if (l != CH_NUL) begin
            burst[3'(n)] = l;
            n = n + 1;
          end
        end
        pat_dashes = 6'd0;
        pat_len = 3'd0;
        if (space_count == RUN_WORD) begin
          burst[3'(n)] = CH_SPACE;
          n = n + 1;
          space_count = 2'd0;
        end else begin
          space_count = space_count + 2'd1;
        end
      end
      if (eot) begin
        l = letter_of(pat_len, pat_dashes);
        if (l != CH_NUL) begin
          burst[3'(n)] = l;
          n = n + 1;
        end
        pat_dashes = 6'd0;
        pat_len = 3'd0;
        space_count = 2'd0;
      end
    end
    for (int i = 0; i < n; i++) begin
      expected_chars.push_back({burst[3'(i)], i == n - 1});
    end
  endtask

  always @(posedge clk) begin
    out_char_t want;
    if (rst) begin
      expected_chars.delete();
      mode = MODE_ENCODE;
      pat_dashes = 6'd0;
      pat_len = 3'd0;
      space_count = 2'd0;
    end else begin
      // a result never comes from a request taken at the same edge
      if (m_tvalid && m_tready) begin
        if (expected_chars.size() == 0) begin
          $display("%0t: unexpected char %h last %b", $time, m_tdata, m_tlast);
          errors++;
        end else begin
          want = expected_chars.pop_front();
          if (m_tdata !== want.ch || m_tlast !== want.last) begin
            $display("%0t: expected char %h last %b, got char %h last %b",
                     $time, want.ch, want.last, m_tdata, m_tlast);
            errors++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        translate_item(s_tdata, s_tlast);
      end
      if (cfg_we) begin
        mode = cfg_wdata;
      end
    end
    fail_count <= errors;
    pending <= expected_chars.size();
  end

endmodule

/* bench/morse_text_codec_top_tb.sv */
// testbench top for the morse text codec: clock, reset, mode writes and
// request stimulus with random stalls; verdict from morse_text_codec_checker
// depends on mtc_pkg, morse_text_codec_top and morse_text_codec_checker
module morse_text_codec_top_tb import mtc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 2000;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic       cfg_wdata;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;
  logic       s_tlast;
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;
  logic       m_tlast;
  int         fail_count;
  int         pending;
  int         send_idle_pct;
  int         recv_idle_pct;

  morse_text_codec_top i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast)
  );

  morse_text_codec_checker i_checker (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast),
    .fail_count (fail_count),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("Simulation FAILED");
    $finish;
  end

  function automatic logic rare_eot();
    return $urandom_range(19) == 0;
  endfunction

  // called and returns at a falling edge
  task automatic send_char(input logic [7:0] c, input logic eot);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= c;
    s_tlast  <= eot;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_text(input string s, input logic eot_last);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], eot_last && i == s.len() - 1);
    end
  endtask

  // mode changes only once the codec has drained
  task automatic set_mode(input logic m);
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic encode_random(input int count);
    logic [7:0] c;
    int         r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(99);
      if (r < 55) begin
        c = SYM_CHARS[6'($urandom_range(SYM_COUNT - 1))];
        if (c >= "A" && c <= "Z" && $urandom_range(1) == 1) begin
          c = c + CASE_OFS;
        end
      end else if (r < 70) begin
        c = CH_SPACE;
      end else begin
        c = 8'($urandom_range(255));
      end
      send_char(c, 1'($urandom_range(1)));
    end
  endtask

  // mostly real letters with space runs, some overlong runs and noise bytes
  task automatic decode_random(input int count);
    int        sent;
    int        r;
    sym_code_t code;
    sent = 0;
    while (sent < count) begin
      r = $urandom_range(99);
      if (r < 70) begin
        code = sym_encode(SYM_CHARS[6'($urandom_range(SYM_COUNT - 1))]);
        for (int k = 5; k >= 0; k--) begin
          if (k < code.len) begin
            send_char(code.bits[3'(k)] ? CH_DASH : CH_DOT, rare_eot());
            sent++;
          end
        end
        repeat ($urandom_range(1, 4)) begin
          send_char(CH_SPACE, rare_eot());
          sent++;
        end
      end else if (r < 85) begin
        repeat ($urandom_range(1, 9)) begin
          send_char($urandom_range(1) ? CH_DASH : CH_DOT, rare_eot());
          sent++;
        end
      end else begin
        send_char(8'($urandom_range(255)), rare_eot());
        sent++;
      end
    end
  endtask

  initial begin
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_wdata = 1'b0;
    s_tvalid = 1'b0;
    s_tdata = 8'h00;
    s_tlast = 1'b0;
    send_idle_pct = 35;
    recv_idle_pct = 59;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // encode: lower case, word space, unknown bytes, end mark ignored
    set_mode(MODE_ENCODE);
    send_text("Az 9?", 1'b0);
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b1);
    send_char("{", 1'b0);

    // decode: overlong run, ignored byte, word space, unknown pattern, flush
    set_mode(MODE_DECODE);
    send_text("-------x   ", 1'b0);
    send_text("..-- ", 1'b0);
    send_text(".-", 1'b1);

    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 35 : (ph == 1) ? 59 : 0;
      recv_idle_pct = (ph == 0) ? 59 : (ph == 1) ? 35 : 0;
      set_mode(MODE_ENCODE);
      encode_random(25);
      // decode state left over from here carries through the next encode
      set_mode(MODE_DECODE);
      decode_random(25);
    end

    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
